[src/vn2_pkg.sv]
`default_nettype none
package vn2_pkg;

   // Widths of the datapath.
   localparam int COORD_W  = 32;
   localparam int EXT_W    = 33;   // coordinate with room for doubling
   localparam int FRAC_W   = 17;   // signed fraction in (-1, 1), Q.16
   localparam int HASH_W   = 32;
   localparam int SUM_W    = 36;   // weighted 3x3 sum
   localparam int ITP_W    = 36;   // interpolated values
   localparam int PERS_W   = 16;
   localparam int OUT_W    = 19;
   localparam int GRID     = 16;   // 4x4 lattice neighborhood per octave

   // Hash constants.
   localparam logic [HASH_W-1:0] HASH_MUL_Y = 32'd57;
   localparam int                HASH_SHIFT = 13;
   localparam logic [HASH_W-1:0] HASH_K1    = 32'd15731;
   localparam logic [HASH_W-1:0] HASH_K2    = 32'd789221;
   localparam logic [HASH_W-1:0] HASH_K3    = 32'd1376312589;
   localparam logic [HASH_W-1:0] HASH_MASK  = 32'h7fffffff;
   localparam logic [HASH_W-1:0] HASH_BIAS  = 32'h40000000;

   // Register file.
   localparam int                CSR_AW        = 3;
   localparam logic [CSR_AW-1:0] REG_PERSIST   = 3'd0;
   localparam logic [PERS_W-1:0] PERSIST_RESET = 16'd1638;

   // Output range.
   localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sh3ffff;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 19'sh40000;

   // Pipeline depth: input register, octave pipe, scale stage, output register.
   localparam int OCT_LAT = 10;
   localparam int PIPE_LAT = OCT_LAT + 3;

   typedef struct packed {
      logic [HASH_W-1:0]        ipart;
      logic signed [FRAC_W-1:0] frac;
   } split_type;

   // Integer part truncated toward zero (wrapped to 32 bits) and signed fraction.
   function automatic split_type split_coord(logic signed [EXT_W-1:0] c);
      logic signed [FRAC_W-1:0] ip;
      logic                     adj;
      split_type                r;
      adj = c[EXT_W-1] && (c[15:0] != 16'd0);
      ip = c[EXT_W-1:16] + {{(FRAC_W-1){1'b0}}, adj};
      r.ipart = {{(HASH_W-FRAC_W){ip[FRAC_W-1]}}, ip};
      r.frac = {adj, c[15:0]};
      return r;
   endfunction

endpackage
`default_nettype wire

[src/value_noise_2d_two_octave.sv]
`default_nettype none
// Two-octave 2D value noise.
// The request channel carries a point (req_coord_x, req_coord_y) in signed
// Q16.16; the response channel returns one word, rsp_noise_value, in signed
// Q2.16, saturated. Both channels use valid/stall; a word moves at a clock
// edge where valid is high and stall is low.
// The block is a 13-stage pipeline: input register, octave pipes, scale stage
// and output register; every stage holds while a valid response is stalled. A
// new request is taken every cycle unless the pipeline holds for a stalled
// response, so throughput is one word per clock while nothing stalls.
// When the receiver stalls while a response is valid, the whole pipeline
// holds, and req_stall is raised until the response is taken.
// The persistence register (octave 1 amplitude, Q0.16) sits at APB address 0
// and is set to 1638 by reset. Reset empties the pipeline; there is no
// clearing pass.
module value_noise_2d_two_octave (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [vn2_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [vn2_pkg::COORD_W-1:0] req_coord_y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [vn2_pkg::OUT_W-1:0]        rsp_noise_value,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [vn2_pkg::CSR_AW-1:0]         paddr,
   input  wire logic [31:0]                        pwdata,
   output logic [31:0]                             prdata,
   output logic                                    pready
);
   logic adv;
   logic [vn2_pkg::PIPE_LAT-1:0] vld_ff, vld_in;
   logic [vn2_pkg::PERS_W-1:0] pers_ff, pers_in;
   logic signed [vn2_pkg::COORD_W-1:0] x_ff, y_ff;
   logic signed [vn2_pkg::ITP_W-1:0] o0, o1, o0d_ff;
   logic signed [52:0] p1_ff;
   logic signed [vn2_pkg::ITP_W:0] total;
   logic signed [22:0] r;
   logic signed [vn2_pkg::OUT_W-1:0] noise_ff, noise_in;

   // The pipeline moves unless a finished word is held by the receiver.
   assign adv       = !(vld_ff[vn2_pkg::PIPE_LAT-1] && rsp_stall);
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[vn2_pkg::PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   // Configuration register.
   assign pready  = 1'b1;
   assign prdata  = (paddr == vn2_pkg::REG_PERSIST) ? {16'd0, pers_ff} : 32'd0;
   assign pers_in = (psel && penable && pwrite && paddr == vn2_pkg::REG_PERSIST)
                    ? pwdata[vn2_pkg::PERS_W-1:0] : pers_ff;

   always_ff @(posedge clock) begin
      if (reset) pers_ff <= vn2_pkg::PERSIST_RESET;
      else pers_ff <= pers_in;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= req_coord_x;
         y_ff <= req_coord_y;
      end
   end

   vn2_octave u_oct0 (
      .clock (clock),
      .en    (adv),
      .cx    (vn2_pkg::EXT_W'(x_ff)),
      .cy    (vn2_pkg::EXT_W'(y_ff)),
      .o     (o0)
   );

   vn2_octave u_oct1 (
      .clock (clock),
      .en    (adv),
      .cx    ({x_ff, 1'b0}),
      .cy    ({y_ff, 1'b0}),
      .o     (o1)
   );

   // Scale octave 1, then sum, rescale and saturate.
   assign total = (vn2_pkg::ITP_W+1)'(o0d_ff) + (vn2_pkg::ITP_W+1)'(p1_ff >>> 16);
   assign r = 23'(total >>> 14);

   always_comb begin
      if (r > 23'(vn2_pkg::OUT_MAX)) noise_in = vn2_pkg::OUT_MAX;
      else if (r < 23'(vn2_pkg::OUT_MIN)) noise_in = vn2_pkg::OUT_MIN;
      else noise_in = r[vn2_pkg::OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff    <= o1 * $signed({1'b0, pers_ff});
         o0d_ff   <= o0;
         noise_ff <= noise_in;
      end
   end

   assign rsp_valid       = vld_ff[vn2_pkg::PIPE_LAT-1];
   assign rsp_noise_value = noise_ff;

   a_stall_only_on_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted word not tracked");
endmodule
`default_nettype wire

[src/vn2_hash.sv]
`default_nettype none
// Lattice hash, three register stages, result mapped to signed Q.30.
module vn2_hash (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [vn2_pkg::HASH_W-1:0]        n,
   output logic signed [vn2_pkg::HASH_W-1:0]      h
);
   logic [vn2_pkg::HASH_W-1:0] mix;
   logic [vn2_pkg::HASH_W-1:0] n2_ff, n2_d_ff, sq_ff, sq_in, p_ff, p_in, t_ff, t_in;

   // Scramble and square, then the two multiply-add steps of the polynomial.
   assign mix   = (n << vn2_pkg::HASH_SHIFT) ^ n;
   assign sq_in = mix * mix;
   assign p_in  = sq_ff * vn2_pkg::HASH_K1 + vn2_pkg::HASH_K2;
   assign t_in  = n2_d_ff * p_ff + vn2_pkg::HASH_K3;

   always_ff @(posedge clock) begin
      if (en) begin
         n2_ff   <= mix;
         sq_ff   <= sq_in;
         n2_d_ff <= n2_ff;
         p_ff    <= p_in;
         t_ff    <= t_in;
      end
   end

   // Map to (-1, 1] in Q.30.
   assign h = $signed(vn2_pkg::HASH_BIAS - (t_ff & vn2_pkg::HASH_MASK));
endmodule
`default_nettype wire

[src/vn2_octave.sv]
`default_nettype none
// One octave: lattice split, 16 hashes, 3x3 smoothing, bilinear blend.
module vn2_octave (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [vn2_pkg::EXT_W-1:0]   cx,
   input  wire logic signed [vn2_pkg::EXT_W-1:0]   cy,
   output logic signed [vn2_pkg::ITP_W-1:0]        o
);
   vn2_pkg::split_type sx, sy;
   logic [vn2_pkg::HASH_W-1:0] ux_ff, uy_ff;
   logic signed [vn2_pkg::FRAC_W-1:0] fx_ff [6];
   logic signed [vn2_pkg::FRAC_W-1:0] fy_ff [8];
   logic [vn2_pkg::HASH_W-1:0] n_ff [vn2_pkg::GRID];
   logic signed [vn2_pkg::HASH_W-1:0] h [vn2_pkg::GRID];
   logic signed [vn2_pkg::HASH_W-1:0] s_ff [4];
   logic signed [vn2_pkg::SUM_W-1:0] sum_in [4];
   logic signed [vn2_pkg::HASH_W-1:0] a1_ff, a2_ff;
   logic signed [49:0] d1_ff, d2_ff;
   logic signed [vn2_pkg::ITP_W-1:0] i1_ff, i2_ff, i1d_ff, o_ff;
   logic signed [52:0] dy_ff;

   assign sx = vn2_pkg::split_coord(cx);
   assign sy = vn2_pkg::split_coord(cy);

   // Stage 1: lattice split; fractions travel alongside.
   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff <= sx.ipart;
         uy_ff <= sy.ipart;
         fx_ff[0] <= sx.frac;
         fy_ff[0] <= sy.frac;
         for (int k = 1; k < 6; k++) fx_ff[k] <= fx_ff[k-1];
         for (int k = 1; k < 8; k++) fy_ff[k] <= fy_ff[k-1];
      end
   end

   // Stage 2: hash seeds over the 4x4 neighborhood, then the hash pipes.
   for (genvar j = 0; j < 4; j++) begin : g_row
      for (genvar i = 0; i < 4; i++) begin : g_col
         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[j*4+i] <= (ux_ff + 32'(i - 1)) + (uy_ff + 32'(j - 1)) * vn2_pkg::HASH_MUL_Y;
            end
         end
         vn2_hash u_hash (
            .clock (clock),
            .en    (en),
            .n     (n_ff[j*4+i]),
            .h     (h[j*4+i])
         );
      end
   end

   // Smoothing: weights 1, 2, 4 around each cell corner, floor divide by 16.
   for (genvar c = 0; c < 4; c++) begin : g_smooth
      localparam int CX = c % 2;
      localparam int CY = c / 2;
      always_comb begin
         sum_in[c] = '0;
         for (int dj = 0; dj < 3; dj++) begin
            for (int di = 0; di < 3; di++) begin
               sum_in[c] = sum_in[c] + ((vn2_pkg::SUM_W'(h[(CY+dj)*4 + CX+di]))
                           <<< (((di == 1) ? 1 : 0) + ((dj == 1) ? 1 : 0)));
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) s_ff[c] <= sum_in[c][vn2_pkg::SUM_W-1:4];
      end
   end

   // Horizontal blend: product, then add; the vertical blend follows in the same way.
   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff  <= (33'(s_ff[1]) - 33'(s_ff[0])) * fx_ff[5];
         d2_ff  <= (33'(s_ff[3]) - 33'(s_ff[2])) * fx_ff[5];
         a1_ff  <= s_ff[0];
         a2_ff  <= s_ff[2];
         i1_ff  <= vn2_pkg::ITP_W'(a1_ff) + vn2_pkg::ITP_W'(d1_ff >>> 16);
         i2_ff  <= vn2_pkg::ITP_W'(a2_ff) + vn2_pkg::ITP_W'(d2_ff >>> 16);
         dy_ff  <= (i2_ff - i1_ff) * fy_ff[7];
         i1d_ff <= i1_ff;
         o_ff   <= i1d_ff + vn2_pkg::ITP_W'(dy_ff >>> 16);
      end
   end

   assign o = o_ff;
endmodule
`default_nettype wire

[tb/tb_value_noise_2d_two_octave.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_value_noise_2d_two_octave;

   localparam int DRAIN_CYCLES = vn2_pkg::PIPE_LAT + 20;
   localparam int IDLE_LIMIT   = 2000;
   localparam int N_RANDOM     = 400;
   localparam int QUIET_TAIL   = 60;
   localparam int HOLD_CYCLES  = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [vn2_pkg::COORD_W-1:0] req_coord_x = '0;
   logic signed [vn2_pkg::COORD_W-1:0] req_coord_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [vn2_pkg::OUT_W-1:0] rsp_noise_value;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [vn2_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   value_noise_2d_two_octave u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_noise_value(rsp_noise_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Local copy of the persistence register and the expected noise words.
   logic [vn2_pkg::PERS_W-1:0] persist_amp;
   logic signed [vn2_pkg::OUT_W-1:0] noise_fifo[$];
   int mismatch_cnt = 0;
   int idle_cycles = 0;
   int hold_cnt = 0;
   int stall_left = 0;
   bit rsp_quiet = 1'b0;
   bit hold_rsp = 1'b0;
   bit failed = 1'b0;

   // Arithmetic shift on a signed value floors toward minus infinity.
   function automatic longint floor_div(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint lattice_value(logic [31:0] x, logic [31:0] y);
      logic [31:0] n;
      logic [31:0] t;
      n = x + y * 32'd57;
      n = (n << 13) ^ n;
      t = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
      t &= 32'h7fffffff;
      return longint'(1073741824) - longint'(t);
   endfunction

   function automatic longint blurred_value(logic [31:0] x, logic [31:0] y);
      longint c4;
      longint s4;
      c4 = lattice_value(x - 1, y - 1) + lattice_value(x + 1, y - 1)
         + lattice_value(x - 1, y + 1) + lattice_value(x + 1, y + 1);
      s4 = lattice_value(x - 1, y) + lattice_value(x + 1, y)
         + lattice_value(x, y - 1) + lattice_value(x, y + 1);
      return floor_div(c4 + 2 * s4 + 4 * lattice_value(x, y), 4);
   endfunction

   function automatic longint blend(longint a, longint b, longint f);
      return a + floor_div((b - a) * f, 16);
   endfunction

   // Truncating division toward zero gives a signed fraction.
   function automatic longint octave_value(longint cx, longint cy);
      longint ix;
      longint iy;
      longint fx;
      longint fy;
      logic [31:0] ux;
      logic [31:0] uy;
      longint top;
      longint bot;
      ix = cx / 65536;
      iy = cy / 65536;
      fx = cx - ix * 65536;
      fy = cy - iy * 65536;
      ux = ix[31:0];
      uy = iy[31:0];
      top = blend(blurred_value(ux, uy), blurred_value(ux + 1, uy), fx);
      bot = blend(blurred_value(ux, uy + 1), blurred_value(ux + 1, uy + 1), fx);
      return blend(top, bot, fy);
   endfunction

   function automatic logic signed [vn2_pkg::OUT_W-1:0] noise_at(logic signed [31:0] x,
                                                                 logic signed [31:0] y);
      longint sx;
      longint sy;
      longint total;
      longint r;
      sx = longint'(x);
      sy = longint'(y);
      total = octave_value(sx, sy)
            + floor_div(octave_value(2 * sx, 2 * sy) * longint'(persist_amp), 16);
      r = floor_div(total, 14);
      if (r > 262143) r = 262143;
      if (r < -262144) r = -262144;
      return r[vn2_pkg::OUT_W-1:0];
   endfunction

   // Directed words: corner and edge coordinates, all checked by the predictor.
   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } point_type;

   point_type directed[] = '{
      '{32'sh00000000, 32'sh00000000},
      '{32'sh7fffffff, 32'sh7fffffff},
      '{32'sh80000000, 32'sh80000000},
      '{32'sh7fffffff, 32'sh80000000},
      '{32'sh80000000, 32'sh7fffffff},
      '{32'shffffffff, 32'shffffffff},
      '{32'sh00000001, 32'sh00000001},
      '{32'shffff0000, 32'sh00010000},
      '{32'sh0000ffff, 32'shffff0001},
      '{32'sh00008000, 32'sh00008000},
      '{32'shffff8000, 32'shffff8000},
      '{32'sh40000000, 32'shc0000000},
      '{32'sh55555555, 32'shaaaaaaaa},
      '{32'shaaaaaaaa, 32'sh55555555},
      '{32'sh00123456, 32'shfedcba98},
      '{32'sh7fff8000, 32'sh80008000}
   };

   // Acceptance of request words and comparison of response words.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_valid && !req_stall)
            noise_fifo.push_back(noise_at(req_coord_x, req_coord_y));
         if (rsp_valid && !rsp_stall) begin
            if (noise_fifo.size() == 0) begin
               failed = 1'b1;
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected word: noise_value=%0d", rsp_noise_value);
            end else begin
               if (rsp_noise_value !== noise_fifo[0]) begin
                  failed = 1'b1;
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("noise_value mismatch: expected %0d, got %0d",
                              noise_fifo[0], rsp_noise_value);
               end
               void'(noise_fifo.pop_front());
            end
         end
      end
   end

   // Receiver stall: short random bursts, one long counted hold, quiet near the end.
   always @(posedge clock) begin
      if (hold_rsp && hold_cnt < HOLD_CYCLES)
         hold_cnt <= hold_cnt + 1;
      if (reset || rsp_quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (hold_rsp && hold_cnt < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic csr_write(logic [vn2_pkg::CSR_AW-1:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == vn2_pkg::REG_PERSIST)
         persist_amp = data[vn2_pkg::PERS_W-1:0];
   endtask

   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, bit gaps);
      if (gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic finish_send();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      int n;
      n = 0;
      while (noise_fifo.size() != 0 && n < 50000) begin
         @(posedge clock);
         n++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
         2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
         default: return $signed($urandom_range(0, 32'h3ff)) - 32'sh200;
      endcase
   endfunction

   logic [15:0] pers_set[] = '{16'd0, 16'd65535, 16'd1638, 16'd32768};

   initial begin
      int k;
      persist_amp = vn2_pkg::PERSIST_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset persistence.
      foreach (directed[i])
         send_point(directed[i].x, directed[i].y, 1'b0);
      finish_send();
      drain();

      // Random words under several persistence settings.
      foreach (pers_set[p]) begin
         csr_write(vn2_pkg::REG_PERSIST, {16'd0, pers_set[p]});
         send_point(32'sh7fffffff, 32'sh80000000, 1'b0);
         for (k = 0; k < N_RANDOM / 4; k++) begin
            if (p == 1 && k == 10) hold_rsp = 1'b1;
            if (p == 3 && k == N_RANDOM / 4 - QUIET_TAIL / 2) rsp_quiet = 1'b1;
            send_point(rand_coord(), rand_coord(), !rsp_quiet);
         end
         finish_send();
         drain();
      end

      if (noise_fifo.size() != 0) failed = 1'b1;
      if (!failed) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
